@@ rtl/core/complex_arithmetic_unit_assert.svh @@
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CAU_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT_IMPL(label, clk, rst, prop, msg)
`define CAU_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ rtl/core/cau_pkg.sv @@
`timescale 1ns / 1ps
package cau_pkg;
   localparam logic [2:0] FUNC_ADD = 3'd0;
   localparam logic [2:0] FUNC_SUB = 3'd1;
   localparam logic [2:0] FUNC_MUL = 3'd2;
   localparam logic [2:0] FUNC_DIV = 3'd3;
   localparam logic [2:0] FUNC_POW = 3'd4;
   localparam logic [2:0] FUNC_MOD = 3'd5;
   localparam logic [2:0] FUNC_CMP = 3'd6;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_OVF  = 2'd1;
   localparam logic [1:0] STATUS_DIV0 = 2'd2;

   typedef logic [2:0] func_type;
endpackage

@@ rtl/core/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// channel | ports    | tdata fields (low bit up)
// request | req_*    | func[2:0] a_re a_im b_re b_im exponent[3:0], zero fill to 136 bits
// result  | rsp_*    | res_re res_im is_equal status[1:0], zero fill to 72 bits
// add, subtract, compare, unused code, power up to 1: result formed at acceptance, then S_OUT raises the result valid
// multiply: four passes through the shared multiplier; power: one such multiply per step, exponent minus one steps
// divide: two restoring divides, real part then imaginary part; zero divisor: no divide is run
// modulus: one root bit per cycle in the shared root unit
// one item at a time; req_tready is low from acceptance until the result is taken
// reset clears the sequencer and the result valid
`include "complex_arithmetic_unit_assert.svh"
module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int WORD_BITS    = 32,
   parameter int FRAC_BITS    = 16,
   parameter int MAX_EXPONENT = 15
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // func, a_re, a_im, b_re, b_im, exponent
   input  logic [((3 + 4 * WORD_BITS + 4 + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // res_re, res_im, is_equal, status
   output logic [((2 * WORD_BITS + 3 + 7) / 8) * 8 - 1:0] rsp_tdata
);
   localparam int W   = WORD_BITS;
   localparam int PW  = 2 * W + 2;           // signed product/sum width
   localparam int NW  = 2 * W + FRAC_BITS + 2; // dividend magnitude width
   localparam int DW  = 2 * W + 1;           // divisor magnitude width
   localparam int CW  = $clog2(NW + 1);
   localparam int EW  = $clog2(MAX_EXPONENT + 1);
   localparam int OW  = ((2 * W + 3 + 7) / 8) * 8;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_M0   = 4'd1;
   localparam logic [3:0] S_M1   = 4'd2;
   localparam logic [3:0] S_M2   = 4'd3;
   localparam logic [3:0] S_M3   = 4'd4;
   localparam logic [3:0] S_MFIN = 4'd5;
   localparam logic [3:0] S_DIVR = 4'd6;
   localparam logic [3:0] S_DIVI = 4'd7;
   localparam logic [3:0] S_SQRT = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;
   localparam logic [3:0] S_I0   = 4'd10;
   localparam logic [3:0] S_I1   = 4'd11;
   localparam logic [3:0] S_I2   = 4'd12;

   logic [3:0] state_ff, state_in;
   func_type func_ff, func_in;
   logic signed [W-1:0] ar_ff, ai_ff, br_ff, bi_ff, pr_ff, pi_ff;
   logic signed [W-1:0] ar_in, ai_in, br_in, bi_in, pr_in, pi_in;
   logic [EW-1:0] steps_ff, steps_in;
   logic signed [PW-1:0] acc0_ff, acc1_ff, acc0_in, acc1_in;
   logic signed [W-1:0] rre_ff, rim_ff, rre_in, rim_in;
   logic eq_ff, eq_in, ovf_ff, ovf_in;
   logic [1:0] st_ff, st_in;
   logic valid_ff, valid_in;
   // shared iterative divider / root
   logic [NW-1:0] num_ff, num_in;
   logic [NW:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic qneg_ff, qneg_in;

   // shared multiplier
   logic signed [W-1:0] mx, my;
   logic signed [2*W-1:0] mp;
   logic signed [2*W-1:0] mp_ff;
   assign mp = mx * my;

   function automatic logic signed [W-1:0] sat_fn(input logic signed [PW-1:0] v,
                                                  output logic o);
      logic signed [PW-1:0] hi, lo;
      begin
         hi = (PW'(1) <<< (W - 1)) - PW'(1);
         lo = -hi - PW'(1);
         o = 1'b0;
         if (v > hi) begin
            o = 1'b1;
            sat_fn = hi[W-1:0];
         end else if (v < lo) begin
            o = 1'b1;
            sat_fn = lo[W-1:0];
         end else begin
            sat_fn = v[W-1:0];
         end
      end
   endfunction

   // truncate toward zero by 2^FRAC_BITS
   function automatic logic signed [PW-1:0] trunc_fn(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      begin
         t = (v < 0) ? -v : v;
         t = t >>> FRAC_BITS;
         trunc_fn = (v < 0) ? -t : t;
      end
   endfunction

   logic [W-1:0] in_ar, in_ai, in_br, in_bi;
   func_type in_func;
   logic [3:0] in_exp;
   assign in_func = req_tdata[2:0];
   assign in_ar = req_tdata[3 +: W];
   assign in_ai = req_tdata[3 + W +: W];
   assign in_br = req_tdata[3 + 2 * W +: W];
   assign in_bi = req_tdata[3 + 3 * W +: W];
   assign in_exp = req_tdata[3 + 4 * W +: 4];

   assign req_tready = (state_ff == S_IDLE) && !valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = OW'({st_ff, eq_ff, rim_ff, rre_ff});

   logic signed [PW-1:0] sum_a, sum_b, tr0, tr1, mag0;
   logic o0, o1;
   logic signed [W-1:0] s0, s1;
   logic [NW:0] trial;
   logic [NW-1:0] qn;
   logic [DW-1:0] dn;
   logic [EW-1:0] ex_c;

   always_comb begin
      state_in = state_ff; func_in = func_ff;
      ar_in = ar_ff; ai_in = ai_ff; br_in = br_ff; bi_in = bi_ff;
      pr_in = pr_ff; pi_in = pi_ff; steps_in = steps_ff;
      acc0_in = acc0_ff; acc1_in = acc1_ff;
      rre_in = rre_ff; rim_in = rim_ff; eq_in = eq_ff; ovf_in = ovf_ff; st_in = st_ff;
      valid_in = valid_ff;
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; qneg_in = qneg_ff;
      mx = pr_ff; my = br_ff;
      sum_a = '0; sum_b = '0; tr0 = '0; tr1 = '0; mag0 = '0;
      o0 = 1'b0; o1 = 1'b0; s0 = '0; s1 = '0;
      trial = '0; qn = '0; dn = '0;
      ex_c = (32'(in_exp) > MAX_EXPONENT) ? EW'(MAX_EXPONENT) : EW'(in_exp);
      if (valid_ff && rsp_tready) valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               func_in = in_func;
               ar_in = in_ar; ai_in = in_ai; br_in = in_br; bi_in = in_bi;
               ovf_in = 1'b0; eq_in = 1'b0; st_in = STATUS_OK;
               rre_in = '0; rim_in = '0;
               steps_in = (ex_c > 1) ? ex_c - EW'(1) : '0;
               unique case (in_func)
                  FUNC_ADD, FUNC_SUB: begin
                     sum_a = (in_func == FUNC_ADD) ?
                        PW'($signed(in_ar)) + PW'($signed(in_br)) :
                        PW'($signed(in_ar)) - PW'($signed(in_br));
                     sum_b = (in_func == FUNC_ADD) ?
                        PW'($signed(in_ai)) + PW'($signed(in_bi)) :
                        PW'($signed(in_ai)) - PW'($signed(in_bi));
                     rre_in = sat_fn(sum_a, o0);
                     rim_in = sat_fn(sum_b, o1);
                     st_in = (o0 || o1) ? STATUS_OVF : STATUS_OK;
                     state_in = S_OUT;
                  end
                  FUNC_CMP: begin
                     eq_in = (in_ar == in_br) && (in_ai == in_bi);
                     state_in = S_OUT;
                  end
                  FUNC_MUL: begin
                     pr_in = in_ar; pi_in = in_ai;
                     state_in = S_M0;
                  end
                  FUNC_POW: begin
                     pr_in = in_ar; pi_in = in_ai;
                     br_in = in_ar; bi_in = in_ai;
                     if (ex_c > 1) state_in = S_M0;
                     else begin
                        rre_in = in_ar; rim_in = in_ai;
                        state_in = S_OUT;
                     end
                  end
                  FUNC_DIV: begin
                     pr_in = in_br; pi_in = in_bi;
                     state_in = S_M0;
                  end
                  FUNC_MOD: begin
                     pr_in = in_ar; pi_in = in_ai; br_in = in_ar; bi_in = in_ai;
                     state_in = S_M0;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         // four multiplier passes; operand pairs depend on the operation
         S_M0: begin
            mx = pr_ff;
            my = (func_ff == FUNC_DIV) ? br_ff : br_ff;
            state_in = S_M1;
         end
         S_M1: begin
            acc0_in = PW'(mp_ff);
            mx = pi_ff; my = bi_ff;
            state_in = S_M2;
         end
         S_M2: begin
            // re: pr*br - pi*bi for multiply and power; + for divide denominator and modulus
            if (func_ff == FUNC_MUL || func_ff == FUNC_POW)
               acc0_in = acc0_ff - PW'(mp_ff);
            else acc0_in = acc0_ff + PW'(mp_ff);
            mx = (func_ff == FUNC_DIV) ? ar_ff : pi_ff;
            my = (func_ff == FUNC_DIV) ? br_ff : br_ff;
            state_in = S_M3;
         end
         S_M3: begin
            acc1_in = PW'(mp_ff);
            mx = (func_ff == FUNC_DIV) ? ai_ff : pr_ff;
            my = bi_ff;
            state_in = S_MFIN;
         end
         S_MFIN: begin
            if (func_ff == FUNC_MUL || func_ff == FUNC_POW) begin
               sum_b = acc1_ff + PW'(mp_ff);
               tr0 = trunc_fn(acc0_ff);
               tr1 = trunc_fn(sum_b);
               s0 = sat_fn(tr0, o0);
               s1 = sat_fn(tr1, o1);
               ovf_in = ovf_ff || o0 || o1;
               if (func_ff == FUNC_POW && steps_ff > 1) begin
                  steps_in = steps_ff - EW'(1);
                  pr_in = s0; pi_in = s1;
                  state_in = S_M0;
               end else begin
                  rre_in = s0; rim_in = s1;
                  st_in = (ovf_ff || o0 || o1) ? STATUS_OVF : STATUS_OK;
                  state_in = S_OUT;
               end
            end else if (func_ff == FUNC_MOD) begin
               // floor sqrt, one result bit per cycle on the shared remainder register
               // aligned so the bit pairs cover the whole sum of squares
               num_in = NW'(acc0_ff) << FRAC_BITS;
               rem_in = '0; quo_in = '0;
               cnt_in = CW'(W + 1);
               state_in = S_SQRT;
            end else begin
               // divide: acc0 holds the denominator; set up pass for the real part
               den_in = DW'(acc0_ff);
               // real numerator = ar*br + ai*bi: use acc1 (ar*br) + ai*bi (current product)
               sum_a = acc1_ff + PW'(mp_ff);
               acc1_in = sum_a; // keep for setup below
               if (acc0_ff == 0) begin
                  st_in = STATUS_DIV0;
                  state_in = S_OUT;
               end else begin
                  mag0 = (sum_a < 0) ? -sum_a : sum_a;
                  qneg_in = sum_a < 0;
                  num_in = NW'(mag0) << FRAC_BITS;
                  rem_in = '0; quo_in = '0; cnt_in = CW'(NW);
                  state_in = S_DIVR;
               end
            end
         end
         S_DIVR, S_DIVI: begin
            // one restoring divide step per cycle
            trial = {rem_ff[NW-1:0], num_ff[NW-1]};
            qn = {quo_ff[NW-2:0], 1'b0};
            if (trial >= (NW+1)'(den_ff)) begin
               trial = trial - (NW+1)'(den_ff);
               qn[0] = 1'b1;
            end
            rem_in = trial; quo_in = qn;
            num_in = {num_ff[NW-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               tr0 = qneg_ff ? -PW'(qn) : PW'(qn);
               if (qn > NW'({1'b1, {(W-1){1'b0}}})) tr0 = qneg_ff ? -(PW'(1) <<< W)
                                                           : (PW'(1) <<< W);
               s0 = sat_fn(tr0, o0);
               ovf_in = ovf_ff || o0;
               if (state_ff == S_DIVR) begin
                  rre_in = s0;
                  state_in = S_I0;
               end else begin
                  rim_in = s0;
                  st_in = (ovf_ff || o0) ? STATUS_OVF : STATUS_OK;
                  state_in = S_OUT;
               end
            end
         end
         // imaginary numerator ai*br - ar*bi on the shared multiplier
         S_I0: begin
            mx = ai_ff; my = br_ff;
            state_in = S_I1;
         end
         S_I1: begin
            acc1_in = PW'(mp_ff);
            mx = ar_ff; my = bi_ff;
            state_in = S_I2;
         end
         S_I2: begin
            sum_b = acc1_ff - PW'(mp_ff);
            mag0 = (sum_b < 0) ? -sum_b : sum_b;
            qneg_in = sum_b < 0;
            num_in = NW'(mag0) << FRAC_BITS;
            rem_in = '0; quo_in = '0; cnt_in = CW'(NW);
            state_in = S_DIVI;
         end
         S_SQRT: begin
            // bit-pair digit recurrence
            trial = {rem_ff[NW-2:0], num_ff[NW-1 -: 2]};
            dn = DW'({quo_ff, 2'b01});
            qn = {quo_ff[NW-2:0], 1'b0};
            if (trial >= (NW+1)'(dn)) begin
               trial = trial - (NW+1)'(dn);
               qn[0] = 1'b1;
            end
            rem_in = trial; quo_in = qn;
            num_in = {num_ff[NW-3:0], 2'b00};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               rre_in = sat_fn(PW'(qn), o0);
               st_in = o0 ? STATUS_OVF : STATUS_OK;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!valid_ff) begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      mp_ff <= mp;
      func_ff <= func_in;
      ar_ff <= ar_in; ai_ff <= ai_in; br_ff <= br_in; bi_ff <= bi_in;
      pr_ff <= pr_in; pi_ff <= pi_in; steps_ff <= steps_in;
      acc0_ff <= acc0_in; acc1_ff <= acc1_in;
      rre_ff <= rre_in; rim_ff <= rim_in; eq_ff <= eq_in; ovf_ff <= ovf_in; st_ff <= st_in;
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      cnt_ff <= cnt_in; qneg_ff <= qneg_in;
   end

   `CAU_ASSERT_IMPL(a_busy_not_ready, clock, reset, (state_ff != S_IDLE) |-> !req_tready, "ready while busy")
   `CAU_ASSERT_IMPL(a_status_code, clock, reset, rsp_tvalid |-> (st_ff != 2'd3), "bad status")
   `CAU_ASSERT_IMPL(a_eq_only_cmp, clock, reset, (rsp_tvalid && eq_ff) |-> (func_ff == FUNC_CMP), "equal flag on non-compare")
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import cau_pkg::*;

   localparam int FB = 16;
   localparam int MAXEXP = 15;
   localparam logic [2:0] FUNC_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        eq;
      logic [1:0]  st;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [135:0] req_tdata = '0;  // func, a_re, a_im, b_re, b_im, exponent
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [71:0] rsp_tdata;        // res_re, res_im, is_equal, status

   result_type expected_q[$];
   int errors = 0;
   int cycles = 0;
   int hold_cycles = 0;

   complex_arithmetic_unit DUT (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // saturate a wide signed value, flag overflow
   function automatic logic [31:0] clamp(input logic signed [199:0] v, inout logic ovf);
      if (v > 200'sd2147483647) begin
         ovf = 1;
         return 32'h7fffffff;
      end
      if (v < -200'sd2147483648) begin
         ovf = 1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // divide truncating toward zero
   function automatic logic signed [199:0] tdiv(input logic signed [199:0] n,
                                                input logic signed [199:0] d);
      logic signed [199:0] q;
      q = (n < 0 ? -n : n) / d;
      return n < 0 ? -q : q;
   endfunction

   function automatic void cmul(input logic [31:0] xr, xi, yr, yi,
                                output logic [31:0] zr, zi, inout logic ovf);
      logic signed [199:0] p, q;
      p = $signed(xr) * $signed(yr) - $signed(xi) * $signed(yi);
      q = $signed(xi) * $signed(yr) + $signed(xr) * $signed(yi);
      zr = clamp(tdiv(p, 200'sd1 <<< FB), ovf);
      zi = clamp(tdiv(q, 200'sd1 <<< FB), ovf);
   endfunction

   function automatic result_type alu_result(input logic [2:0] f, input logic [31:0] ar, ai,
                                             br, bi, input logic [3:0] ex);
      result_type r;
      logic ovf;
      logic signed [199:0] den, n, s;
      logic [199:0] sq, root;
      int e;
      r = '0;
      ovf = 0;
      e = ex > MAXEXP ? MAXEXP : ex;
      case (f)
         FUNC_ADD: begin
            r.re = clamp($signed(ar) + $signed(br), ovf);
            r.im = clamp($signed(ai) + $signed(bi), ovf);
         end
         FUNC_SUB: begin
            r.re = clamp($signed(ar) - $signed(br), ovf);
            r.im = clamp($signed(ai) - $signed(bi), ovf);
         end
         FUNC_MUL: cmul(ar, ai, br, bi, r.re, r.im, ovf);
         FUNC_DIV: begin
            den = $signed(br) * $signed(br) + $signed(bi) * $signed(bi);
            if (den == 0) begin
               r.st = STATUS_DIV0;
            end else begin
               n = $signed(ar) * $signed(br) + $signed(ai) * $signed(bi);
               r.re = clamp(tdiv(n <<< FB, den), ovf);
               n = $signed(ai) * $signed(br) - $signed(ar) * $signed(bi);
               r.im = clamp(tdiv(n <<< FB, den), ovf);
            end
         end
         FUNC_POW: begin
            r.re = ar;
            r.im = ai;
            for (int i = 1; i < e; i++) cmul(r.re, r.im, ar, ai, r.re, r.im, ovf);
         end
         FUNC_MOD: begin
            s = $signed(ar) * $signed(ar) + $signed(ai) * $signed(ai);
            sq = s;
            root = 0;
            for (int b = 40; b >= 0; b--)
               if ((root | (200'd1 << b)) * (root | (200'd1 << b)) <= sq)
                  root = root | (200'd1 << b);
            r.re = clamp($signed(root), ovf);
         end
         FUNC_CMP: r.eq = (ar == br) && (ai == bi);
         default: ;
      endcase
      if (r.st == STATUS_OK && ovf) r.st = STATUS_OVF;
      return r;
   endfunction

   task automatic send_item(input logic [2:0] f, input logic [31:0] ar, ai, br, bi,
                            input logic [3:0] ex, input bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 6) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, ex, bi, br, ai, ar, f};
      expected_q.push_back(alu_result(f, ar, ai, br, bi, ex));
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] rnd_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3ffff)
                                        : -$urandom_range(0, 32'h3ffff);
         3: return 0;
         default: return $urandom;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.re = rsp_tdata[31:0];
         got.im = rsp_tdata[63:32];
         got.eq = rsp_tdata[64];
         got.st = rsp_tdata[66:65];
         if (expected_q.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            exp_r = expected_q.pop_front();
            if (got.re !== exp_r.re) begin
               $error("res_re expected %h actual %h", exp_r.re, got.re); errors++;
            end
            if (got.im !== exp_r.im) begin
               $error("res_im expected %h actual %h", exp_r.im, got.im); errors++;
            end
            if (got.eq !== exp_r.eq) begin
               $error("is_equal expected %b actual %b", exp_r.eq, got.eq); errors++;
            end
            if (got.st !== exp_r.st) begin
               $error("status expected %0d actual %0d", exp_r.st, got.st); errors++;
            end
         end
      end
   end

   // receiver stalls
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 0;
            hold_cycles = hold_cycles - 1;
         end else if (rsp_tready && rsp_tvalid) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            rsp_tready <= gap == 0;
            hold_cycles = gap > 0 ? gap - 1 : 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   task automatic wait_drain();
      req_tvalid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(FUNC_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff, 4'd0);
      send_item(FUNC_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff, 4'd0);
      send_item(FUNC_ADD, 32'h00010000, 32'hffff0000, 32'h00020000, 32'h3, 4'd0);
      send_item(FUNC_MUL, 32'h00018000, 32'hffff8000, 32'h00000001, 32'hffffffff, 4'd0);
      send_item(FUNC_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 4'd0);
      send_item(FUNC_MUL, 32'hfffffffd, 32'h00000005, 32'h00008000, 32'h0, 4'd0);
      send_item(FUNC_DIV, 32'h00010000, 32'h00020000, 32'h0, 32'h0, 4'd0);
      send_item(FUNC_DIV, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00010000, 4'd0);
      send_item(FUNC_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0, 4'd0);
      send_item(FUNC_DIV, 32'hffffffff, 32'h1, 32'h00070000, 32'hfffd0000, 4'd0);
      send_item(FUNC_POW, 32'h00018000, 32'h00004000, 0, 0, 4'd0);
      send_item(FUNC_POW, 32'h00018000, 32'h00004000, 0, 0, 4'd1);
      send_item(FUNC_POW, 32'h00010000, 32'h00010000, 0, 0, 4'd15);
      send_item(FUNC_POW, 32'h00020000, 32'h0, 0, 0, 4'd15);
      send_item(FUNC_POW, 32'hffff0000, 32'h0, 0, 0, 4'd3);
      send_item(FUNC_MOD, 32'h80000000, 32'h80000000, 0, 0, 4'd0);
      send_item(FUNC_MOD, 32'h00030000, 32'hfffc0000, 0, 0, 4'd0);
      send_item(FUNC_MOD, 32'h0, 32'h0, 0, 0, 4'd0);
      send_item(FUNC_CMP, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef0, 4'd0);
      send_item(FUNC_CMP, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef1, 4'd0);
      send_item(FUNC_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 4'hf);
      wait_drain();
   endtask

   task automatic test_random(input int n);
      logic [2:0] f;
      logic [31:0] ar, ai;
      for (int i = 0; i < n; i++) begin
         f = 3'($urandom_range(0, 7));
         ar = rnd_word();
         ai = rnd_word();
         if (f == FUNC_CMP && $urandom_range(0, 1))
            send_item(f, ar, ai, ar, $urandom_range(0, 1) ? ai : ai ^ (1 << $urandom_range(0, 31)),
                      4'($urandom_range(0, 15)));
         else
            send_item(f, ar, ai, rnd_word(), rnd_word(), 4'($urandom_range(0, 15)));
      end
   endtask

   // long receiver hold while the sender keeps offering
   task automatic test_backpressure();
      @(posedge clock);
      hold_cycles = 300;
      for (int i = 0; i < 20; i++)
         send_item(3'($urandom_range(0, 6)), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                   4'($urandom_range(0, 15)), 0);
      wait_drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(600);
      test_backpressure();
      test_random(600);
      wait_drain();
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
